// ===== sv/bq_pkg.sv =====
// Shared constants and types for the biquadratic real root solver.
package bq_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_BITS     = 26;
  localparam int COUNT_BITS    = 3;

  typedef logic signed [ROOT_BITS-1:0] root_t;
  typedef logic [COUNT_BITS-1:0]       count_t;

  // Placement of the computed magnitudes in the four root slots.
  typedef enum logic [1:0] {
    LAY_ZERO  = 2'd0,
    LAY_PAIR  = 2'd1,
    LAY_ZPAIR = 2'd2,
    LAY_QUAD  = 2'd3
  } layout_t;

  typedef struct packed {
    layout_t layout;
    count_t  count;
    logic    inf;
  } tail_t;

endpackage

// ===== sv/bq_in_if.sv =====
// Input channel carrying the three equation coefficients.
interface bq_in_if #(
  parameter int COEF_BITS = bq_pkg::COEF_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] coef_a;
  logic signed [COEF_BITS-1:0] coef_b;
  logic signed [COEF_BITS-1:0] coef_c;

  modport source(output valid, coef_a, coef_b, coef_c, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// ===== sv/bq_out_if.sv =====
// Output channel carrying the root count and the four roots.
interface bq_out_if;
  logic                 valid;
  logic                 ready;
  logic                 infinite_roots;
  bq_pkg::count_t       root_count;
  bq_pkg::root_t        root_1;
  bq_pkg::root_t        root_2;
  bq_pkg::root_t        root_3;
  bq_pkg::root_t        root_4;

  modport source(output valid, infinite_roots, root_count, root_1, root_2, root_3, root_4,
                 input ready);
  modport sink(input valid, infinite_roots, root_count, root_1, root_2, root_3, root_4,
               output ready);
endinterface

// ===== sv/bq_sqrt_cell.sv =====
// One digit step of a pipelined integer square root, two radicand bits per cell.
module bq_sqrt_cell #(
  parameter int RW    = 8,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*RW-1:0] in_rad  [LANES],
  input  logic [RW+1:0]   in_rem  [LANES],
  input  logic [RW-1:0]   in_root [LANES],
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2*RW-1:0] out_rad  [LANES],
  output logic [RW+1:0]   out_rem  [LANES],
  output logic [RW-1:0]   out_root [LANES],
  output logic [SW-1:0]   out_side
);

  logic            valid;
  logic [2*RW-1:0] rad       [LANES];
  logic [RW+1:0]   rem       [LANES];
  logic [RW-1:0]   root      [LANES];
  logic [SW-1:0]   side;
  logic [2*RW-1:0] rad_next  [LANES];
  logic [RW+1:0]   rem_next  [LANES];
  logic [RW-1:0]   root_next [LANES];
  logic [RW+1:0]   rem_sh    [LANES];
  logic [RW+1:0]   trial     [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // The partial remainder never exceeds twice the partial root, so its low bits suffice.
      rem_sh[l]   = {in_rem[l][RW-1:0], in_rad[l][2*RW-1 -: 2]};
      trial[l]    = {in_root[l], 2'b01};
      rad_next[l] = in_rad[l] << 2;
      if (rem_sh[l] >= trial[l]) begin
        rem_next[l]  = rem_sh[l] - trial[l];
        root_next[l] = {in_root[l][RW-2:0], 1'b1};
      end else begin
        rem_next[l]  = rem_sh[l];
        root_next[l] = {in_root[l][RW-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      side <= in_side;
      for (int l = 0; l < LANES; l++) begin
        rad[l]  <= rad_next[l];
        rem[l]  <= rem_next[l];
        root[l] <= root_next[l];
      end
    end
  end

  assign out_valid = valid;
  assign out_rad   = rad;
  assign out_rem   = rem;
  assign out_root  = root;
  assign out_side  = side;

endmodule

// ===== sv/bq_div_cell.sv =====
// One restoring division step, one quotient bit per cell.
module bq_div_cell #(
  parameter int NW    = 8,
  parameter int DENW  = 4,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [NW-1:0]   in_num [LANES],
  input  logic [DENW-1:0] in_rem [LANES],
  input  logic [DENW-1:0] in_den [LANES],
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [NW-1:0]   out_num [LANES],
  output logic [DENW-1:0] out_rem [LANES],
  output logic [DENW-1:0] out_den [LANES],
  output logic [SW-1:0]   out_side
);

  logic            valid;
  logic [NW-1:0]   num      [LANES];
  logic [DENW-1:0] rem      [LANES];
  logic [DENW-1:0] den      [LANES];
  logic [SW-1:0]   side;
  logic [NW-1:0]   num_next [LANES];
  logic [DENW-1:0] rem_next [LANES];
  logic [DENW:0]   rem_sh   [LANES];
  logic [DENW:0]   rem_sub  [LANES];
  logic            ge       [LANES];

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l]  = {in_rem[l], in_num[l][NW-1]};
      ge[l]      = rem_sh[l] >= {1'b0, in_den[l]};
      rem_sub[l] = ge[l] ? rem_sh[l] - {1'b0, in_den[l]} : rem_sh[l];
      rem_next[l] = rem_sub[l][DENW-1:0];
      num_next[l] = {in_num[l][NW-2:0], ge[l]};
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      side <= in_side;
      for (int l = 0; l < LANES; l++) begin
        num[l] <= num_next[l];
        rem[l] <= rem_next[l];
        den[l] <= in_den[l];
      end
    end
  end

  assign out_valid = valid;
  assign out_num   = num;
  assign out_rem   = rem;
  assign out_den   = den;
  assign out_side  = side;

endmodule

// ===== sv/biquadratic_real_root_solver_top.sv =====
// Top level of the biquadratic real root solver.
// Solves a*x^4 + b*x^2 + c = 0 for its real roots, returned in Q(FRAC_BITS) with truncated
// magnitudes. The block is fully pipelined: it takes one equation per cycle while the output
// is not held back, and returns one result item per equation, in order. It is built from the
// stage 1 to 4 registers, RFW = COEF_BITS + 2*FRAC_BITS + 1 square root cells on the
// discriminant, NUW = COEF_BITS + 2*FRAC_BITS + 2 divider cells, QRW = ceil(NUW/2) square
// root cells on the quotient and the output register. Each stage stalls only when the stage
// after it is full and held, so bubbles are squeezed out under back pressure.
module biquadratic_real_root_solver_top #(
  parameter int COEF_BITS = bq_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = bq_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  bq_in_if.sink       eqn,
  bq_out_if.source    sol
);
  import bq_pkg::*;

  localparam int NB   = COEF_BITS + 1;
  localparam int DW   = 2 * COEF_BITS + 2;
  localparam int RFW  = COEF_BITS + 2 * FRAC_BITS + 1;
  localparam int NW   = COEF_BITS + 2 * FRAC_BITS + 3;
  localparam int NUW  = NW - 1;
  localparam int DENW = NB;
  localparam int QRW  = (NUW + 1) / 2;

  typedef struct packed {
    logic az;
    logic bz;
    logic bneg;
    logic cz;
    logic cneg;
  } signs_t;

  typedef struct packed {
    logic signed [NW-1:0] base;
    logic [DENW-1:0]      den;
    logic                 dpos;
    tail_t                tail;
  } sidea_t;

  localparam int SWA = $bits(sidea_t);
  localparam int SWT = $bits(tail_t);

  // Stage 1: sign normalization.
  logic                 p1_v, p1_rdy;
  logic signed [NB-1:0] p1_a, p1_b, p1_c;
  logic signed [NB-1:0] ea, eb, ec;
  logic                 neg;

  // Stage 2: products.
  logic                   p2_v, p2_rdy;
  logic signed [2*NB-1:0] p2_bb, p2_ac;
  logic signed [NB-1:0]   p2_negx;
  logic [DENW-1:0]        p2_den;
  signs_t                 p2_sg;

  // Stage 3: discriminant and case decode.
  logic                 p3_v, p3_rdy;
  logic [2*RFW-1:0]     p3_rad;
  sidea_t               p3_side;
  logic signed [DW-1:0] dd;
  logic                 dpos, dzero;
  logic                 bpos, cpos, s1pos, s1zero, s1neg, s2pos, s2zero;
  tail_t                tl;

  // Stage 4: numerators.
  logic                 p4_v, p4_rdy;
  logic [NUW-1:0]       p4_num [2];
  logic [DENW-1:0]      p4_den;
  tail_t                p4_tail;
  sidea_t               sa;
  logic [RFW-1:0]       rf;
  logic                 perfect;
  logic signed [NW-1:0] num1, num2;

  // Output register.
  logic   o_v, o_rdy;
  logic   o_inf;
  count_t o_cnt;
  root_t  o_r1, o_r2, o_r3, o_r4;
  root_t  rq1, rq2;
  tail_t  ct;

  // Cell chains.
  logic             a_v    [RFW+1];
  logic             a_rdy  [RFW+1];
  logic [2*RFW-1:0] a_rad  [RFW+1][1];
  logic [RFW+1:0]   a_rem  [RFW+1][1];
  logic [RFW-1:0]   a_root [RFW+1][1];
  logic [SWA-1:0]   a_side [RFW+1];

  logic             b_v    [NUW+1];
  logic             b_rdy  [NUW+1];
  logic [NUW-1:0]   b_num  [NUW+1][2];
  logic [DENW-1:0]  b_rem  [NUW+1][2];
  logic [DENW-1:0]  b_den  [NUW+1][2];
  logic [SWT-1:0]   b_side [NUW+1];

  logic             c_v    [QRW+1];
  logic             c_rdy  [QRW+1];
  logic [2*QRW-1:0] c_rad  [QRW+1][2];
  logic [QRW+1:0]   c_rem  [QRW+1][2];
  logic [QRW-1:0]   c_root [QRW+1][2];
  logic [SWT-1:0]   c_side [QRW+1];

  // ---------------- Stage 1 ----------------
  // Flip all signs so that a, or b when a is zero, is not negative.
  always_comb begin
    ea  = NB'(eqn.coef_a);
    eb  = NB'(eqn.coef_b);
    ec  = NB'(eqn.coef_c);
    neg = (ea == '0) ? (eb < 0) : (ea < 0);
  end

  assign p1_rdy    = !p1_v || p2_rdy;
  assign eqn.ready = p1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (p1_rdy) begin
      p1_v <= eqn.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy) begin
      p1_a <= neg ? -ea : ea;
      p1_b <= neg ? -eb : eb;
      p1_c <= neg ? -ec : ec;
    end
  end

  // ---------------- Stage 2 ----------------
  assign p2_rdy = !p2_v || p3_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (p2_rdy) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy) begin
      p2_bb      <= p1_b * p1_b;
      p2_ac      <= p1_a * p1_c;
      p2_negx    <= (p1_a == '0) ? -p1_c : -p1_b;
      p2_den     <= (p1_a == '0) ? DENW'(p1_b) : DENW'(p1_a <<< 1);
      p2_sg.az   <= p1_a == '0;
      p2_sg.bz   <= p1_b == '0;
      p2_sg.bneg <= p1_b < 0;
      p2_sg.cz   <= p1_c == '0;
      p2_sg.cneg <= p1_c < 0;
    end
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    dd     = DW'(p2_bb) - (DW'(p2_ac) <<< 2);
    dzero  = dd == '0;
    dpos   = !dd[DW-1] && !dzero;
    bpos   = !p2_sg.bneg && !p2_sg.bz;
    cpos   = !p2_sg.cneg && !p2_sg.cz;
    // Signs of the smaller root t1 and the larger root t2, from b and c alone.
    s1neg  = bpos || p2_sg.cneg;
    s1zero = !bpos && p2_sg.cz;
    s1pos  = !bpos && cpos;
    s2pos  = p2_sg.bneg || p2_sg.cneg;
    s2zero = !p2_sg.bneg && p2_sg.cz;
    tl.layout = LAY_ZERO;
    tl.count  = '0;
    tl.inf    = 1'b0;
    if (p2_sg.az) begin
      if (p2_sg.bz) begin
        tl.inf = p2_sg.cz;
      end else if (p2_sg.cneg) begin
        tl.layout = LAY_PAIR;
        tl.count  = 3'd2;
      end else if (p2_sg.cz) begin
        tl.count  = 3'd1;
      end
    end else if (dzero) begin
      if (p2_sg.bneg) begin
        tl.layout = LAY_PAIR;
        tl.count  = 3'd2;
      end else if (p2_sg.bz) begin
        tl.count  = 3'd1;
      end
    end else if (dpos) begin
      if (s1zero && s2pos) begin
        tl.layout = LAY_ZPAIR;
        tl.count  = 3'd3;
      end else if (s1neg && s2pos) begin
        tl.layout = LAY_PAIR;
        tl.count  = 3'd2;
      end else if (s1pos && s2pos) begin
        tl.layout = LAY_QUAD;
        tl.count  = 3'd4;
      end else if (s1neg && s2zero) begin
        tl.count  = 3'd1;
      end
    end
  end

  assign p3_rdy = !p3_v || a_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (p3_rdy) begin
      p3_v <= p2_v;
    end
  end

  // The linear equation has no discriminant term in its numerator.
  always_ff @(posedge clk) begin
    if (p3_rdy) begin
      p3_rad       <= {(dpos ? dd : DW'(0)), {(4 * FRAC_BITS){1'b0}}};
      p3_side.base <= NW'(p2_negx) <<< (2 * FRAC_BITS);
      p3_side.den  <= p2_den;
      p3_side.dpos <= dpos && !p2_sg.az;
      p3_side.tail <= tl;
    end
  end

  // ---------------- Square root of the scaled discriminant ----------------
  assign a_v[0]       = p3_v;
  assign a_rad[0][0]  = p3_rad;
  assign a_rem[0][0]  = '0;
  assign a_root[0][0] = '0;
  assign a_side[0]    = p3_side;
  assign a_rdy[RFW]   = p4_rdy;

  for (genvar i = 0; i < RFW; i++) begin : g_sqd
    bq_sqrt_cell #(
      .RW   (RFW),
      .LANES(1),
      .SW   (SWA)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (a_v[i]),
      .in_ready (a_rdy[i]),
      .in_rad   (a_rad[i]),
      .in_rem   (a_rem[i]),
      .in_root  (a_root[i]),
      .in_side  (a_side[i]),
      .out_valid(a_v[i+1]),
      .out_ready(a_rdy[i+1]),
      .out_rad  (a_rad[i+1]),
      .out_rem  (a_rem[i+1]),
      .out_root (a_root[i+1]),
      .out_side (a_side[i+1])
    );
  end

  // ---------------- Stage 4 ----------------
  // A zero remainder means the discriminant is a perfect square and the scaled root is exact;
  // otherwise the smaller root uses the ceiling of the scaled root.
  always_comb begin
    sa      = sidea_t'(a_side[RFW]);
    rf      = a_root[RFW][0];
    perfect = a_rem[RFW][0] == '0;
    num2    = sa.base + (sa.dpos ? NW'(rf) : NW'(0));
    num1    = sa.base - NW'(rf) - NW'(!perfect);
  end

  assign p4_rdy = !p4_v || b_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (p4_rdy) begin
      p4_v <= a_v[RFW];
    end
  end

  always_ff @(posedge clk) begin
    if (p4_rdy) begin
      p4_num[0] <= num1[NW-1] ? NUW'(0) : num1[NUW-1:0];
      p4_num[1] <= num2[NW-1] ? NUW'(0) : num2[NUW-1:0];
      p4_den    <= sa.den;
      p4_tail   <= sa.tail;
    end
  end

  // ---------------- Division ----------------
  assign b_v[0]      = p4_v;
  assign b_num[0][0] = p4_num[0];
  assign b_num[0][1] = p4_num[1];
  assign b_rem[0][0] = '0;
  assign b_rem[0][1] = '0;
  assign b_den[0][0] = p4_den;
  assign b_den[0][1] = p4_den;
  assign b_side[0]   = p4_tail;
  assign b_rdy[NUW]  = c_rdy[0];

  for (genvar i = 0; i < NUW; i++) begin : g_div
    bq_div_cell #(
      .NW   (NUW),
      .DENW (DENW),
      .LANES(2),
      .SW   (SWT)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (b_v[i]),
      .in_ready (b_rdy[i]),
      .in_num   (b_num[i]),
      .in_rem   (b_rem[i]),
      .in_den   (b_den[i]),
      .in_side  (b_side[i]),
      .out_valid(b_v[i+1]),
      .out_ready(b_rdy[i+1]),
      .out_num  (b_num[i+1]),
      .out_rem  (b_rem[i+1]),
      .out_den  (b_den[i+1]),
      .out_side (b_side[i+1])
    );
  end

  // ---------------- Square root of the quotients ----------------
  assign c_v[0]       = b_v[NUW];
  assign c_rad[0][0]  = (2 * QRW)'(b_num[NUW][0]);
  assign c_rad[0][1]  = (2 * QRW)'(b_num[NUW][1]);
  assign c_rem[0][0]  = '0;
  assign c_rem[0][1]  = '0;
  assign c_root[0][0] = '0;
  assign c_root[0][1] = '0;
  assign c_side[0]    = b_side[NUW];
  assign c_rdy[QRW]   = o_rdy;

  for (genvar i = 0; i < QRW; i++) begin : g_sqq
    bq_sqrt_cell #(
      .RW   (QRW),
      .LANES(2),
      .SW   (SWT)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (c_v[i]),
      .in_ready (c_rdy[i]),
      .in_rad   (c_rad[i]),
      .in_rem   (c_rem[i]),
      .in_root  (c_root[i]),
      .in_side  (c_side[i]),
      .out_valid(c_v[i+1]),
      .out_ready(c_rdy[i+1]),
      .out_rad  (c_rad[i+1]),
      .out_rem  (c_rem[i+1]),
      .out_root (c_root[i+1]),
      .out_side (c_side[i+1])
    );
  end

  // ---------------- Output register ----------------
  always_comb begin
    ct  = tail_t'(c_side[QRW]);
    rq1 = ROOT_BITS'(c_root[QRW][0]);
    rq2 = ROOT_BITS'(c_root[QRW][1]);
  end

  assign o_rdy = !o_v || sol.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_rdy) begin
      o_v <= c_v[QRW];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_inf <= ct.inf;
      o_cnt <= ct.count;
      unique case (ct.layout)
        LAY_PAIR: begin
          o_r1 <= -rq2;
          o_r2 <= rq2;
          o_r3 <= '0;
          o_r4 <= '0;
        end
        LAY_ZPAIR: begin
          o_r1 <= '0;
          o_r2 <= -rq2;
          o_r3 <= rq2;
          o_r4 <= '0;
        end
        LAY_QUAD: begin
          o_r1 <= -rq1;
          o_r2 <= rq1;
          o_r3 <= -rq2;
          o_r4 <= rq2;
        end
        default: begin
          o_r1 <= '0;
          o_r2 <= '0;
          o_r3 <= '0;
          o_r4 <= '0;
        end
      endcase
    end
  end

  assign sol.valid          = o_v;
  assign sol.infinite_roots = o_inf;
  assign sol.root_count     = o_cnt;
  assign sol.root_1         = o_r1;
  assign sol.root_2         = o_r2;
  assign sol.root_3         = o_r3;
  assign sol.root_4         = o_r4;

`ifndef SYNTH
  a_inf_no_roots: assert property (@(posedge clk) disable iff (rst)
    sol.valid && sol.infinite_roots |-> sol.root_count == '0 && sol.root_1 == '0)
    else $error("infinite solution item carries roots");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sol.valid |-> sol.root_count <= 3'd4)
    else $error("root count above four");

  a_pair_mirror: assert property (@(posedge clk) disable iff (rst)
    sol.valid && (sol.root_count == 3'd2 || sol.root_count == 3'd4)
      |-> ROOT_BITS'(sol.root_1 + sol.root_2) == '0)
    else $error("first root pair is not symmetric");

  a_quad_mirror: assert property (@(posedge clk) disable iff (rst)
    sol.valid && sol.root_count == 3'd4 |-> ROOT_BITS'(sol.root_3 + sol.root_4) == '0)
    else $error("second root pair is not symmetric");

  a_capture: assert property (@(posedge clk) disable iff (rst)
    eqn.valid && eqn.ready |=> p1_v)
    else $error("accepted item not captured by the first stage");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the biquadratic real root solver.
module testbench;
  import bq_pkg::*;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } eqn_t;

  typedef struct packed {
    logic   inf;
    count_t count;
    root_t  r1;
    root_t  r2;
    root_t  r3;
    root_t  r4;
  } roots_t;

  logic clk;
  logic rst;

  bq_in_if  #(.COEF_BITS(16)) eqn ();
  bq_out_if sol ();

  biquadratic_real_root_solver_top #(.COEF_BITS(16), .FRAC_BITS(16)) i_dut (
    .clk (clk),
    .rst (rst),
    .eqn (eqn.sink),
    .sol (sol.source)
  );

  eqn_t   pending_eqns[$];
  roots_t expected_roots[$];
  int     send_idle_pct;
  int     recv_idle_pct;
  int     mismatches;
  int     solved;
  int     quad_seen;
  int     inf_seen;

  // Floor square root of a 128-bit value, two bits per step.
  function automatic logic [63:0] isqrt_q(input logic [127:0] v);
    logic [63:0] root;
    logic [67:0] rem;
    logic [67:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | v[2*i +: 2];
      trial = ({4'b0, root} << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint mag_of(input longint num, input longint den);
    longint tk;
    if (num <= 0 || den <= 0) return 0;
    tk = num / den;
    return longint'(isqrt_q({64'd0, tk}));
  endfunction

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic roots_t solve_biquad(input eqn_t e);
    longint a, b, c, d, k, q1, q2, rf, rc, s0;
    longint r[4];
    int     n, sg1, sg2;
    roots_t res;
    a = e.a;
    b = e.b;
    c = e.c;
    k = 64'sd1 <<< 32;
    n = 0;
    r = '{0, 0, 0, 0};
    res = '0;
    if (a == 0) begin
      if (b == 0) begin
        if (c == 0) res.inf = 1'b1;
      end else begin
        if (b < 0) begin
          b = -b;
          c = -c;
        end
        if (c < 0) begin
          q1 = mag_of(-c * k, b);
          r[0] = -q1;
          r[1] = q1;
          n = 2;
        end else if (c == 0) begin
          n = 1;
        end
      end
    end else begin
      if (a < 0) begin
        a = -a;
        b = -b;
        c = -c;
      end
      d = b * b - 4 * a * c;
      if (d == 0) begin
        if (b < 0) begin
          q1 = mag_of(-b * k, 2 * a);
          r[0] = -q1;
          r[1] = q1;
          n = 2;
        end else if (b == 0) begin
          n = 1;
        end
      end else if (d > 0) begin
        rf = longint'(isqrt_q({d, 64'd0}));
        s0 = longint'(isqrt_q({64'd0, d}));
        rc = rf + ((s0 * s0 != d) ? 1 : 0);
        sg1 = (b > 0) ? -1 : sign_of(c);
        sg2 = (b < 0) ? 1 : -sign_of(c);
        q1 = 0;
        q2 = 0;
        if (sg2 > 0) q2 = mag_of(-b * k + rf, 2 * a);
        if (sg1 > 0) q1 = mag_of(-b * k - rc, 2 * a);
        if (sg1 == 0 && sg2 > 0) begin
          r[1] = -q2;
          r[2] = q2;
          n = 3;
        end else if (sg1 < 0 && sg2 > 0) begin
          r[0] = -q2;
          r[1] = q2;
          n = 2;
        end else if (sg1 > 0 && sg2 > 0) begin
          r[0] = -q1;
          r[1] = q1;
          r[2] = -q2;
          r[3] = q2;
          n = 4;
        end else if (sg1 < 0 && sg2 == 0) begin
          n = 1;
        end
      end
    end
    res.count = count_t'(n);
    res.r1 = root_t'(r[0]);
    res.r2 = root_t'(r[1]);
    res.r3 = root_t'(r[2]);
    res.r4 = root_t'(r[3]);
    return res;
  endfunction

  function automatic eqn_t mk(input int a, input int b, input int c);
    eqn_t e;
    e.a = a[15:0];
    e.b = b[15:0];
    e.c = c[15:0];
    return e;
  endfunction

  // Just under half are equations built from chosen roots in t, the rest small or fully random.
  function automatic eqn_t random_eqn();
    int sel, a, t1, t2, b, c;
    sel = $urandom_range(99);
    if (sel < 45) begin
      a  = $urandom_range(40) - 20;
      t1 = $urandom_range(60) - 20;
      t2 = $urandom_range(60) - 20;
      b  = -a * (t1 + t2);
      c  = a * t1 * t2;
      if (b >= -32768 && b <= 32767 && c >= -32768 && c <= 32767) return mk(a, b, c);
      return mk(a, 0, -a);
    end else if (sel < 65) begin
      return mk($urandom_range(8) - 4, $urandom_range(16) - 8, $urandom_range(16) - 8);
    end else begin
      return mk($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    end
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    eqn.valid  = 1'b0;
    eqn.coef_a = '0;
    eqn.coef_b = '0;
    eqn.coef_c = '0;
    sol.ready  = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender side: one nonblocking update per edge.
  always @(posedge clk) begin
    if (rst) begin
      eqn.valid <= 1'b0;
    end else if (!eqn.valid || eqn.ready) begin
      if (pending_eqns.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        eqn_t e;
        e = pending_eqns.pop_front();
        eqn.coef_a <= e.a;
        eqn.coef_b <= e.b;
        eqn.coef_c <= e.c;
        eqn.valid  <= 1'b1;
      end else begin
        eqn.valid <= 1'b0;
      end
    end
  end

  // Receiver side, prediction on acceptance and checking of results.
  always @(posedge clk) begin
    if (rst) begin
      sol.ready <= 1'b0;
    end else begin
      sol.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (eqn.valid && eqn.ready)
        expected_roots.push_back(solve_biquad({eqn.coef_a, eqn.coef_b, eqn.coef_c}));
      if (sol.valid && sol.ready) begin
        roots_t got, want;
        got = {sol.infinite_roots, sol.root_count, sol.root_1, sol.root_2, sol.root_3,
               sol.root_4};
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = expected_roots.pop_front();
          solved++;
          if (want.count == 4) quad_seen++;
          if (want.inf) inf_seen++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected inf=%0d n=%0d %0d %0d %0d %0d, got inf=%0d n=%0d %0d %0d %0d %0d",
                       want.inf, want.count, want.r1, want.r2, want.r3, want.r4,
                       got.inf, got.count, got.r1, got.r2, got.r3, got.r4);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_eqns.size() > 0 || eqn.valid || expected_roots.size() > 0) @(posedge clk);
  endtask

  initial begin
    mismatches = 0;
    solved = 0;
    quad_seen = 0;
    inf_seen = 0;
    send_idle_pct = 6;
    recv_idle_pct = 46;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Directed cases: extremes and each branch of the solver.
    pending_eqns.push_back(mk(0, 0, 0));
    pending_eqns.push_back(mk(0, 0, 5));
    pending_eqns.push_back(mk(0, 3, -12));
    pending_eqns.push_back(mk(0, -3, 12));
    pending_eqns.push_back(mk(0, 7, 0));
    pending_eqns.push_back(mk(0, 2, 9));
    pending_eqns.push_back(mk(1, -4, 4));
    pending_eqns.push_back(mk(1, 0, 0));
    pending_eqns.push_back(mk(1, 4, 4));
    pending_eqns.push_back(mk(1, -5, 4));
    pending_eqns.push_back(mk(1, -3, 0));
    pending_eqns.push_back(mk(1, 3, 0));
    pending_eqns.push_back(mk(2, -1, -6));
    pending_eqns.push_back(mk(1, 1, 1));
    pending_eqns.push_back(mk(-1, 5, -4));
    pending_eqns.push_back(mk(1, 5, 6));
    pending_eqns.push_back(mk(-32768, -32768, -32768));
    pending_eqns.push_back(mk(32767, 32767, 32767));
    pending_eqns.push_back(mk(1, -32768, 32767));
    pending_eqns.push_back(mk(1, -32768, -32768));
    pending_eqns.push_back(mk(-32768, 32767, 0));
    pending_eqns.push_back(mk(0, 1, -32768));
    pending_eqns.push_back(mk(0, -32768, 32767));
    pending_eqns.push_back(mk(1, 2, 2));
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : ((phase == 1) ? 46 : 0);
      recv_idle_pct = (phase == 0) ? 46 : ((phase == 1) ? 6 : 0);
      for (int i = 0; i < 300; i++) pending_eqns.push_back(random_eqn());
      drain();
    end
    repeat (200) @(posedge clk);
    $display("checked %0d solutions, %0d with four roots, %0d with infinitely many",
             solved, quad_seen, inf_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== biquadratic_real_root_solver_top.f =====
sv/bq_pkg.sv
sv/bq_in_if.sv
sv/bq_out_if.sv
sv/bq_sqrt_cell.sv
sv/bq_div_cell.sv
sv/biquadratic_real_root_solver_top.sv
sim/testbench.sv
